// ===== src/scl_pkg.sv =====
package scl_pkg;

  typedef enum logic [3:0] {
    KIND_END        = 4'd0,
    KIND_WORD       = 4'd1,
    KIND_IN         = 4'd2,
    KIND_OUT        = 4'd3,
    KIND_PIPE       = 4'd4,
    KIND_AND        = 4'd5,
    KIND_OR         = 4'd6,
    KIND_APPEND     = 4'd7,
    KIND_BACKQUOTE  = 4'd8,
    KIND_SEMICOLON  = 4'd9,
    KIND_BACKGROUND = 4'd10,
    KIND_INVALID    = 4'd11
  } token_kind_t;

  localparam int KIND_W   = 4;
  localparam int REPORT_W = 10;
  localparam int TDATA_W  = 24;

  typedef struct packed {
    logic                last;
    logic [REPORT_W-1:0] token_end;
    logic [REPORT_W-1:0] token_start;
    token_kind_t         kind;
  } token_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BQUOTE = 8'h60;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_symbol(input logic [7:0] c);
    return (c == CH_LT) || (c == CH_BAR) || (c == CH_GT) || (c == CH_AMP) ||
           (c == CH_SEMI) || (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_BQUOTE);
  endfunction

endpackage

// ===== src/shell_command_lexer_top.sv =====
// A token caused by an input transfer is registered into the token queue and offered from its head.
// Throughput: one byte per cycle while the queue has room and no byte yields two tokens;
// a byte that closes one token and is itself a whole token yields two, read out in turn.
// A four-entry token queue decouples the sides; input is taken while it has room for two.
// Synchronous active-high reset clears the lexer mode, line offset and the token queue.
module shell_command_lexer_top #(
  parameter int LINE_MAX = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,   // [7:0] ch
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [scl_pkg::TDATA_W-1:0] m_tdata, // [3:0] token_kind, [13:4] token_start,
                                               // [23:14] token_end
  output logic                      m_tlast    // is_last
);
  import scl_pkg::*;

  // Offsets are held at the line's own width and saturate at LINE_MAX-1.
  localparam int OFF_W   = $clog2(LINE_MAX);
  localparam int OFF_MAX = LINE_MAX - 1;
  localparam int CAP_W   = (OFF_W > REPORT_W) ? OFF_W : REPORT_W;
  localparam int Q_DEPTH = 4;
  localparam int PTR_W   = 2;
  localparam int CNT_W   = 3;

  // The lexer mode is one-hot. Tokens whose kind depends on the following byte
  // (>, | and &) keep a mode of their own until that byte arrives.
  typedef enum logic [8:0] {
    M_IDLE    = 9'b000000001,
    M_WORD    = 9'b000000010,
    M_DQ      = 9'b000000100,
    M_BQ      = 9'b000001000,
    M_GT      = 9'b000010000,
    M_BAR     = 9'b000100000,
    M_AMP     = 9'b001000000,
    M_AMPWS   = 9'b010000000,
    M_COMMENT = 9'b100000000
  } mode_t;

  function automatic logic [OFF_W-1:0] sat_inc(input logic [OFF_W-1:0] x);
    return (x < OFF_W'(OFF_MAX)) ? OFF_W'(x + 1'b1) : OFF_W'(OFF_MAX);
  endfunction

  // Reported offsets are further capped to the 10-bit output fields.
  function automatic logic [REPORT_W-1:0] cap(input logic [OFF_W-1:0] x);
    logic [CAP_W-1:0] w;
    w = CAP_W'(x);
    return (w > CAP_W'(1023)) ? REPORT_W'(1023) : w[REPORT_W-1:0];
  endfunction

  mode_t            mode, mode_next;
  logic [OFF_W-1:0] offset, offset_next;
  logic [OFF_W-1:0] start, start_next;

  token_t           queue [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  logic [7:0] c;
  logic       in_xfer, out_xfer;

  // First token: the one closed by this byte in the current mode.
  logic        a_valid;
  token_kind_t a_kind;
  logic [OFF_W-1:0] a_start, a_end;
  logic        call_idle;

  // Second token: the byte lexed again from the idle mode.
  logic        i_valid;
  token_kind_t i_kind;
  logic [OFF_W-1:0] i_start, i_end;
  mode_t       i_mode;
  logic        i_open;

  token_t      res0, res1;
  logic        res0_valid, res1_valid;
  logic [1:0]  push_n;

  assign c        = s_tdata;
  assign s_tready = (count <= CNT_W'(Q_DEPTH - 2));
  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;

  // Idle-mode lexing of the current byte, used from idle and after a token closes.
  always_comb begin
    i_valid = 1'b0;
    i_kind  = KIND_END;
    i_start = offset;
    i_end   = sat_inc(offset);
    i_mode  = M_IDLE;
    i_open  = 1'b0;
    if (c == CH_NUL) begin
      i_valid = 1'b1;
      i_end   = offset;
    end else if (is_space(c)) begin
      i_mode = M_IDLE;
    end else if (c == CH_HASH) begin
      i_mode = M_COMMENT;
    end else if (c == CH_DQUOTE) begin
      i_mode = M_DQ;
      i_open = 1'b1;
    end else if (c == CH_BQUOTE) begin
      i_mode = M_BQ;
      i_open = 1'b1;
    end else if (c == CH_LT) begin
      i_valid = 1'b1;
      i_kind  = KIND_IN;
    end else if (c == CH_SEMI) begin
      i_valid = 1'b1;
      i_kind  = KIND_SEMICOLON;
    end else if ((c == CH_LPAREN) || (c == CH_RPAREN)) begin
      i_valid = 1'b1;
      i_kind  = KIND_INVALID;
    end else if (c == CH_GT) begin
      i_mode = M_GT;
      i_open = 1'b1;
    end else if (c == CH_BAR) begin
      i_mode = M_BAR;
      i_open = 1'b1;
    end else if (c == CH_AMP) begin
      i_mode = M_AMP;
      i_open = 1'b1;
    end else begin
      i_mode = M_WORD;
      i_open = 1'b1;
    end
  end

  // Mode-dependent handling of the byte against the open token.
  always_comb begin
    a_valid   = 1'b0;
    a_kind    = KIND_INVALID;
    a_start   = start;
    a_end     = sat_inc(start);
    call_idle = 1'b0;
    mode_next = mode;
    case (mode)
      M_WORD: begin
        if ((c == CH_NUL) || is_space(c) || is_symbol(c)) begin
          a_valid   = 1'b1;
          a_kind    = KIND_WORD;
          a_end     = offset;
          call_idle = 1'b1;
        end
      end
      M_DQ, M_BQ: begin
        if (((mode == M_DQ) && (c == CH_DQUOTE)) || ((mode == M_BQ) && (c == CH_BQUOTE))) begin
          a_valid   = 1'b1;
          a_kind    = (mode == M_DQ) ? KIND_WORD : KIND_BACKQUOTE;
          a_start   = sat_inc(start);
          a_end     = sat_inc(offset);
          mode_next = M_IDLE;
        end else if (c == CH_NUL) begin
          a_valid   = 1'b1;
          a_kind    = KIND_INVALID;
          a_end     = offset;
          call_idle = 1'b1;
        end
      end
      M_GT, M_BAR: begin
        a_valid = 1'b1;
        if (((mode == M_GT) && (c == CH_GT)) || ((mode == M_BAR) && (c == CH_BAR))) begin
          a_kind    = (mode == M_GT) ? KIND_APPEND : KIND_OR;
          a_end     = sat_inc(offset);
          mode_next = M_IDLE;
        end else begin
          a_kind    = (mode == M_GT) ? KIND_OUT : KIND_PIPE;
          call_idle = 1'b1;
        end
      end
      M_AMP, M_AMPWS: begin
        if ((mode == M_AMP) && (c == CH_AMP)) begin
          a_valid   = 1'b1;
          a_kind    = KIND_AND;
          a_end     = sat_inc(offset);
          mode_next = M_IDLE;
        end else if (is_space(c)) begin
          mode_next = M_AMPWS;
        end else begin
          // A lone & is background only when the line ends next, possibly after whitespace.
          a_valid   = 1'b1;
          a_kind    = (c == CH_NUL) ? KIND_BACKGROUND : KIND_INVALID;
          call_idle = 1'b1;
        end
      end
      M_COMMENT: begin
        call_idle = (c == CH_NUL);
      end
      default: begin
        call_idle = 1'b1;
      end
    endcase

    start_next = start;
    if (call_idle) begin
      mode_next = i_mode;
      if (i_open) begin
        start_next = offset;
      end
    end

    if (c == CH_NUL) begin
      mode_next   = M_IDLE;
      start_next  = '0;
      offset_next = '0;
    end else begin
      offset_next = sat_inc(offset);
    end
  end

  // Pack up to two tokens in emission order; the final one carries last.
  always_comb begin
    res1_valid        = a_valid && call_idle && i_valid;
    res0_valid        = a_valid || (call_idle && i_valid);
    res1.kind         = i_kind;
    res1.token_start  = cap(i_start);
    res1.token_end    = cap(i_end);
    res1.last         = 1'b1;
    if (a_valid) begin
      res0.kind        = a_kind;
      res0.token_start = cap(a_start);
      res0.token_end   = cap(a_end);
    end else begin
      res0.kind        = i_kind;
      res0.token_start = cap(i_start);
      res0.token_end   = cap(i_end);
    end
    res0.last = !res1_valid;
    push_n    = in_xfer ? {res1_valid, res0_valid && !res1_valid} : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      offset <= '0;
      start  <= '0;
    end else if (in_xfer) begin
      mode   <= mode_next;
      offset <= offset_next;
      start  <= start_next;
    end
  end

  // Token queue: writes up to two entries per transfer, reads one per output transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (out_xfer) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push_n) - CNT_W'(out_xfer);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && res0_valid) begin
      queue[wr_ptr] <= res0;
    end
    if (in_xfer && res1_valid) begin
      queue[PTR_W'(wr_ptr + 1'b1)] <= res1;
    end
  end

  assign m_tvalid = (count != '0);
  assign m_tdata  = {queue[rd_ptr].token_end, queue[rd_ptr].token_start,
                     queue[rd_ptr].kind};
  assign m_tlast  = queue[rd_ptr].last;

endmodule

// ===== src/scl_checker.sv =====
module scl_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [scl_pkg::TDATA_W-1:0] m_tdata,
  input logic                        m_tlast
);
  import scl_pkg::*;

  // The queue is empty after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("token offered right after reset");

  // An offered token that is stalled holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled token changed");

  // The end-of-line token is empty and is always the final one of its byte.
  a_end_token: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[3:0] == KIND_END) |-> (m_tdata[13:4] == m_tdata[23:14]) && m_tlast)
    else $error("malformed end-of-line token");

  // No token ends before it starts.
  a_ordered: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[13:4] <= m_tdata[23:14]))
    else $error("token end precedes token start");

endmodule

bind shell_command_lexer_top scl_checker u_scl_checker (.*);

// ===== dv/shell_command_lexer_checker.sv =====
`timescale 1ns / 1ps

// Watches both streams of the lexer, predicts the tokens for every accepted
// byte and compares each accepted token with the oldest prediction.
module shell_command_lexer_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [7:0]                  s_tdata,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [scl_pkg::TDATA_W-1:0] m_tdata,
  input  logic                        m_tlast,
  output int                          fail_count,
  output int                          outstanding,
  output int                          tokens_checked
);

  import scl_pkg::*;

  localparam int         LINE_LIMIT = 1024;
  localparam logic [9:0] OFFSET_MAX = 10'(LINE_LIMIT - 1);

  typedef enum logic [3:0] {
    LX_IDLE,
    LX_WORD,
    LX_DQUOTE,
    LX_BQUOTE,
    LX_GT,
    LX_BAR,
    LX_AMP,
    LX_AMP_SPACE,
    LX_COMMENT
  } lex_mode_t;

  lex_mode_t   mode;
  logic [9:0]  line_pos;
  logic [9:0]  word_start;
  token_t      expected_tokens[$];
  token_t      step_tokens[$];
  token_t      want;
  token_t      tail;
  int          errors;
  int          compared;
  token_kind_t got_kind;
  logic [9:0]  got_start;
  logic [9:0]  got_end;

  function automatic logic [9:0] bump(input logic [9:0] x);
    return (x < OFFSET_MAX) ? x + 10'd1 : OFFSET_MAX;
  endfunction

  function automatic logic blank_char(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  function automatic logic operator_char(input logic [7:0] c);
    return c == CH_LT || c == CH_BAR || c == CH_GT || c == CH_AMP || c == CH_SEMI ||
           c == CH_LPAREN || c == CH_RPAREN || c == CH_BQUOTE;
  endfunction

  task automatic add_token(input token_kind_t k, input logic [9:0] s, input logic [9:0] e);
    token_t t;
    t.kind        = k;
    t.token_start = s;
    t.token_end   = e;
    t.last        = 1'b0;
    step_tokens.push_back(t);
  endtask

  // Lexes a byte with no token open; at most one token comes out of it.
  task automatic start_token(input logic [7:0] c, input logic [9:0] o);
    mode = LX_IDLE;
    if (c == CH_NUL) begin
      add_token(KIND_END, o, o);
    end else if (blank_char(c)) begin
    end else if (c == CH_HASH) begin
      mode = LX_COMMENT;
    end else if (c == CH_DQUOTE) begin
      mode = LX_DQUOTE;
      word_start = o;
    end else if (c == CH_BQUOTE) begin
      mode = LX_BQUOTE;
      word_start = o;
    end else if (c == CH_LT) begin
      add_token(KIND_IN, o, bump(o));
    end else if (c == CH_SEMI) begin
      add_token(KIND_SEMICOLON, o, bump(o));
    end else if (c == CH_LPAREN || c == CH_RPAREN) begin
      add_token(KIND_INVALID, o, bump(o));
    end else if (c == CH_GT) begin
      mode = LX_GT;
      word_start = o;
    end else if (c == CH_BAR) begin
      mode = LX_BAR;
      word_start = o;
    end else if (c == CH_AMP) begin
      mode = LX_AMP;
      word_start = o;
    end else begin
      mode = LX_WORD;
      word_start = o;
    end
  endtask

  task automatic lex_byte(input logic [7:0] c);
    logic [9:0] o;
    logic [9:0] st;
    o  = line_pos;
    st = word_start;
    step_tokens.delete();
    case (mode)
      LX_WORD: begin
        if (c == CH_NUL || blank_char(c) || operator_char(c)) begin
          add_token(KIND_WORD, st, o);
          start_token(c, o);
        end
      end
      LX_DQUOTE, LX_BQUOTE: begin
        if (c == ((mode == LX_DQUOTE) ? CH_DQUOTE : CH_BQUOTE)) begin
          add_token((mode == LX_DQUOTE) ? KIND_WORD : KIND_BACKQUOTE, bump(st), bump(o));
          mode = LX_IDLE;
        end else if (c == CH_NUL) begin
          add_token(KIND_INVALID, st, o);
          start_token(c, o);
        end
      end
      LX_GT, LX_BAR: begin
        if (c == ((mode == LX_GT) ? CH_GT : CH_BAR)) begin
          add_token((mode == LX_GT) ? KIND_APPEND : KIND_OR, st, bump(o));
          mode = LX_IDLE;
        end else begin
          add_token((mode == LX_GT) ? KIND_OUT : KIND_PIPE, st, bump(st));
          start_token(c, o);
        end
      end
      LX_AMP, LX_AMP_SPACE: begin
        // A lone ampersand stays undecided across whitespace until the line
        // ends (background) or something else shows up (invalid).
        if (mode == LX_AMP && c == CH_AMP) begin
          add_token(KIND_AND, st, bump(o));
          mode = LX_IDLE;
        end else if (blank_char(c)) begin
          mode = LX_AMP_SPACE;
        end else if (c == CH_NUL) begin
          add_token(KIND_BACKGROUND, st, bump(st));
          start_token(c, o);
        end else begin
          add_token(KIND_INVALID, st, bump(st));
          start_token(c, o);
        end
      end
      LX_COMMENT: begin
        if (c == CH_NUL) start_token(c, o);
      end
      default: begin
        start_token(c, o);
      end
    endcase

    if (step_tokens.size() > 0) begin
      tail = step_tokens.pop_back();
      tail.last = 1'b1;
      step_tokens.push_back(tail);
    end
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);

    if (c == CH_NUL) begin
      mode       = LX_IDLE;
      line_pos   = '0;
      word_start = '0;
    end else begin
      line_pos = bump(o);
    end
  endtask

  initial begin
    mode       = LX_IDLE;
    line_pos   = '0;
    word_start = '0;
    errors     = 0;
    compared   = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      mode       = LX_IDLE;
      line_pos   = '0;
      word_start = '0;
      expected_tokens.delete();
    end else begin
      if (s_tvalid && s_tready) lex_byte(s_tdata);

      if (m_tvalid && m_tready) begin
        got_kind  = token_kind_t'(m_tdata[3:0]);
        got_start = m_tdata[13:4];
        got_end   = m_tdata[23:14];
        if (expected_tokens.size() == 0) begin
          errors++;
          $display("%0t: token with none expected: kind %0d start %0d end %0d last %0b",
                   $time, got_kind, got_start, got_end, m_tlast);
        end else begin
          want = expected_tokens.pop_front();
          compared++;
          if (got_kind != want.kind || got_start != want.token_start ||
              got_end != want.token_end || m_tlast != want.last) begin
            errors++;
            $display("%0t: token mismatch: expected kind %0d start %0d end %0d last %0b",
                     $time, want.kind, want.token_start, want.token_end, want.last);
            $display("%0t:                 actual   kind %0d start %0d end %0d last %0b",
                     $time, got_kind, got_start, got_end, m_tlast);
          end
        end
      end
    end
    fail_count     <= errors;
    outstanding    <= expected_tokens.size();
    tokens_checked <= compared;
  end

endmodule

// ===== dv/shell_command_lexer_top_tb.sv =====
`timescale 1ns / 1ps

// Testbench for the shell command lexer. The top makes the byte stream and
// paces both sides; the checker beside the block predicts and compares every
// token transfer and reports its failure count here for the verdict.
module shell_command_lexer_top_tb;

  import scl_pkg::*;

  // Cycles without any transfer on either side before the run is declared hung.
  localparam int STALL_LIMIT = 2000;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata  = 8'h00;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [TDATA_W-1:0]   m_tdata;
  logic                 m_tlast;

  int         fail_count;
  int         outstanding;
  int         tokens_checked;
  bit         idle_on = 1'b1;
  int         bytes_sent = 0;
  int         lines_sent = 0;
  int         stall_cycles = 0;
  logic [7:0] line_q[$];

  always #6 clk = ~clk;

  shell_command_lexer_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  shell_command_lexer_checker token_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .tokens_checked (tokens_checked)
  );

  // Watchdog: any transfer on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d tokens still owed",
               $time, STALL_LIMIT, outstanding);
      $display("shell_command_lexer_top regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Token sink pacing. While idling is enabled the sink now and then drops ready for
  // a burst of random length; otherwise it takes every token as soon as offered.
  initial begin : sink_pacing
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (idle_on && hold == 0 && $urandom_range(0, 4) == 0) hold = $urandom_range(1, 6);
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Offers one byte, possibly after a burst of idle cycles, and returns right
  // after the edge that completes its transfer. Valid is only lowered when a
  // gap is inserted, so back-to-back bytes keep it high without a glitch.
  task automatic send_byte(input logic [7:0] c);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  // Sends the bytes gathered so far followed by the terminating zero byte.
  task automatic send_line();
    line_q.push_back(CH_NUL);
    foreach (line_q[i]) send_byte(line_q[i]);
    line_q.delete();
    lines_sent++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  // A byte that can only ever continue a plain word: letters, digits and the
  // upper half of the byte range.
  function automatic logic [7:0] word_byte();
    case ($urandom_range(0, 3))
      0:       return 8'h61 + 8'($urandom_range(0, 25));
      1:       return 8'h41 + 8'($urandom_range(0, 25));
      2:       return 8'h30 + 8'($urandom_range(0, 9));
      default: return 8'($urandom_range(8'h80, 8'hFF));
    endcase
  endfunction

  // Any nonzero byte other than the quote that would close the text.
  function automatic logic [7:0] quoted_byte(input logic [7:0] closer);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == closer);
    return c;
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // Appends one well-formed piece of a command line, or now and then a noise byte.
  task automatic add_fragment();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      repeat ($urandom_range(1, 5)) line_q.push_back(word_byte());
    end else if (pick < 48) begin
      line_q.push_back(CH_DQUOTE);
      repeat ($urandom_range(0, 4)) line_q.push_back(quoted_byte(CH_DQUOTE));
      line_q.push_back(CH_DQUOTE);
    end else if (pick < 54) begin
      line_q.push_back(CH_BQUOTE);
      repeat ($urandom_range(0, 4)) line_q.push_back(quoted_byte(CH_BQUOTE));
      line_q.push_back(CH_BQUOTE);
    end else if (pick < 80) begin
      case ($urandom_range(0, 9))
        0:       add_text("<");
        1:       add_text(">");
        2:       add_text(">>");
        3:       add_text("|");
        4:       add_text("||");
        5:       add_text("&&");
        6:       add_text(";");
        7:       add_text("&");
        8:       add_text("(");
        default: add_text(")");
      endcase
    end else if (pick < 95) begin
      repeat ($urandom_range(1, 3)) line_q.push_back(blank_byte());
    end else begin
      line_q.push_back(8'($urandom_range(1, 255)));
    end
  endtask

  // Builds and sends one random line of at least min_len bytes. Most lines
  // are sequences of well-formed pieces; the ending may be a comment, a
  // trailing background ampersand or an unclosed quote. A few lines are noise.
  task automatic random_line(input int min_len);
    if (min_len == 0 && $urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(1, 8)) add_fragment();
      while (line_q.size() < min_len) add_fragment();
      case ($urandom_range(0, 19))
        0, 1: begin
          line_q.push_back(CH_HASH);
          repeat ($urandom_range(0, 5)) line_q.push_back(8'($urandom_range(1, 255)));
        end
        2, 3: begin
          line_q.push_back(CH_AMP);
          repeat ($urandom_range(0, 2)) line_q.push_back(blank_byte());
        end
        4: begin
          line_q.push_back(CH_DQUOTE);
          repeat ($urandom_range(0, 3)) line_q.push_back(quoted_byte(CH_DQUOTE));
        end
        5: begin
          line_q.push_back(CH_BQUOTE);
          repeat ($urandom_range(0, 3)) line_q.push_back(quoted_byte(CH_BQUOTE));
        end
        default: begin
        end
      endcase
    end
    send_line();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed lines.
    // All-ones word byte, append, then a pipe decided by a word character,
    // which closes the pipe and opens a word in the same transfer.
    line_q.push_back(8'hFF);
    add_text(">>|c");
    send_line();
    // Quoted word, input redirect, backquoted text and a background ampersand
    // that has to look past a tab before the line ends.
    add_text("\"x\"<`y`&\t");
    send_line();
    // And, a lone ampersand made invalid by a semicolon (two tokens at once),
    // a parenthesis, or, and a comment that swallows the rest of the line.
    add_text("&&&;)|| #z");
    send_line();
    // Backquote never closed before the end of the line.
    line_q.push_back(CH_BQUOTE);
    line_q.push_back(8'h01);
    send_line();

    // Random lines with idling on both sides, then a final stretch without.
    while (bytes_sent < 300) random_line(0);
    idle_on = 1'b0;
    while (bytes_sent < 400) random_line(0);

    @(negedge clk);
    s_tvalid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Lexed %0d bytes in %0d directed and random lines, with and without idling.",
             bytes_sent, lines_sent);
    $display("%0d tokens were compared with their predictions.", tokens_checked);
    if (fail_count == 0) begin
      $display("shell_command_lexer_top regression: pass");
    end else begin
      $display("shell_command_lexer_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== shell_command_lexer_top.f =====
src/scl_pkg.sv
src/shell_command_lexer_top.sv
src/scl_checker.sv
dv/shell_command_lexer_checker.sv
dv/shell_command_lexer_top_tb.sv
